/* hdl/wrp_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the wav riff pcm stream parser
// no dependencies; used by wrp_front, wrp_queue, wrp_back and the top level
package wrp_pkg;

	// chunk identifiers, big-endian four-character codes
	localparam logic [31:0] ID_RIFF   = 32'h52494646;
	localparam logic [31:0] ID_FMT    = 32'h666D7420;
	localparam logic [31:0] ID_DATA   = 32'h64617461;
	localparam logic [31:0] FORM_WAVE = 32'h57415645;
	localparam logic [15:0] TAG_EXTENSIBLE = 16'hFFFE;

	// fmt chunk byte counts
	localparam int FMT_BODY_BYTES = 16;
	localparam int FMT_EXT_BYTES  = 24;

	// default depth of the queue between parser and converter
	localparam int QUEUE_DEPTH = 4;

	// result event codes
	localparam logic [2:0] EV_SAMPLE   = 3'd0;
	localparam logic [2:0] EV_FORMAT   = 3'd1;
	localparam logic [2:0] EV_NOT_WAVE = 3'd2;
	localparam logic [2:0] EV_BAD_DATA = 3'd3;
	localparam logic [2:0] EV_SKIPPED  = 3'd4;

	// sample width codes (bytes per sample)
	localparam logic [1:0] NB_8  = 2'd1;
	localparam logic [1:0] NB_16 = 2'd2;
	localparam logic [1:0] NB_24 = 2'd3;

	// one classified result on its way from parser to converter
	typedef struct packed {
		logic [2:0]  event_res;
		logic [23:0] raw;
		logic [1:0]  nb;
		logic [15:0] channel_index;
		logic [15:0] format_tag;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [31:0] bytes_per_second;
		logic [15:0] frame_bytes;
		logic [15:0] sample_bits;
		logic [31:0] skipped_id;
	} entry_t;

endpackage

/* hdl/wrp_front.sv */
`timescale 1ns / 1ps
// byte-wise chunk parser: walks the riff structure and pushes classified results
// depends on wrp_pkg
module wrp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               cmd,
	input  logic [7:0]         data_byte,
	output logic               push,
	output wrp_pkg::entry_t    push_entry
);

	typedef enum logic [3:0] {
		PH_ID, PH_RIFF_SIZE, PH_RIFF_FORM, PH_FMT_SIZE, PH_FMT_BODY, PH_FMT_EXT,
		PH_DATA_SIZE, PH_SAMPLE, PH_SKIP, PH_UNK_SIZE, PH_HALT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [5:0]  cnt_q, cnt_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] left_q, left_d;
	logic [15:0] chan_q, chan_d;
	logic [15:0] tag_q, tag_d;
	logic [15:0] chans_q, chans_d;
	logic [31:0] rate_q, rate_d;
	logic [31:0] brate_q, brate_d;
	logic [15:0] align_q, align_d;
	logic [15:0] bits_q, bits_d;
	logic [17:0] fb_q, fb_d;
	logic [1:0]  nb_q, nb_d;

	logic [5:0]  bump;
	logic [31:0] sh_be;
	logic [31:0] sh_le;
	logic [31:0] left_dec;
	logic [1:0]  nb_fmt;
	logic [17:0] fb_fmt;
	logic        bad_fmt;

	// byte assembly helpers
	always_comb begin
		bump     = cnt_q + 6'd1;
		sh_be    = {shift_q[23:0], data_byte};
		left_dec = left_q - 32'd1;
		unique case (cnt_q[1:0])
			2'd0: sh_le = {shift_q[31:8], data_byte};
			2'd1: sh_le = {shift_q[31:16], data_byte, shift_q[7:0]};
			2'd2: sh_le = {shift_q[31:24], data_byte, shift_q[15:0]};
			default: sh_le = {data_byte, shift_q[23:0]};
		endcase
		// frame size from the format fields
		bad_fmt = 1'b0;
		unique case (bits_q)
			16'd8:  nb_fmt = wrp_pkg::NB_8;
			16'd16: nb_fmt = wrp_pkg::NB_16;
			16'd24: nb_fmt = wrp_pkg::NB_24;
			default: begin
				nb_fmt  = wrp_pkg::NB_8;
				bad_fmt = 1'b1;
			end
		endcase
		if (chans_q == 16'd0) bad_fmt = 1'b1;
		unique case (nb_fmt)
			wrp_pkg::NB_16: fb_fmt = {1'b0, chans_q, 1'b0};
			wrp_pkg::NB_24: fb_fmt = {2'b00, chans_q} + {1'b0, chans_q, 1'b0};
			default:        fb_fmt = {2'b00, chans_q};
		endcase
	end

	// next state and result classification
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		shift_d = shift_q;
		left_d  = left_q;
		chan_d  = chan_q;
		tag_d   = tag_q;
		chans_d = chans_q;
		rate_d  = rate_q;
		brate_d = brate_q;
		align_d = align_q;
		bits_d  = bits_q;
		fb_d    = fb_q;
		nb_d    = nb_q;
		push    = 1'b0;
		push_entry = '0;
		if (accept) begin
			if (cmd) begin
				phase_d = PH_ID;
				cnt_d   = '0;
				shift_d = '0;
				left_d  = '0;
				chan_d  = '0;
				tag_d   = '0;
				chans_d = '0;
				rate_d  = '0;
				brate_d = '0;
				align_d = '0;
				bits_d  = '0;
			end else begin
				cnt_d = bump;
				unique case (phase_q)
					PH_ID: begin
						shift_d = sh_be;
						if (bump == 6'd4) begin
							cnt_d   = '0;
							shift_d = '0;
							if (sh_be == wrp_pkg::ID_RIFF) begin
								phase_d = PH_RIFF_SIZE;
							end else if (sh_be == wrp_pkg::ID_FMT) begin
								tag_d   = '0;
								chans_d = '0;
								rate_d  = '0;
								brate_d = '0;
								align_d = '0;
								bits_d  = '0;
								phase_d = PH_FMT_SIZE;
							end else if (sh_be == wrp_pkg::ID_DATA) begin
								phase_d = PH_DATA_SIZE;
							end else begin
								left_d  = sh_be;
								phase_d = PH_UNK_SIZE;
							end
						end
					end
					PH_RIFF_SIZE, PH_FMT_SIZE: begin
						if (bump == 6'd4) begin
							cnt_d   = '0;
							phase_d = (phase_q == PH_RIFF_SIZE) ? PH_RIFF_FORM : PH_FMT_BODY;
						end
					end
					PH_RIFF_FORM: begin
						shift_d = sh_be;
						if (bump == 6'd4) begin
							cnt_d   = '0;
							shift_d = '0;
							if (sh_be == wrp_pkg::FORM_WAVE) begin
								phase_d = PH_ID;
							end else begin
								phase_d = PH_HALT;
								push    = 1'b1;
								push_entry.event_res = wrp_pkg::EV_NOT_WAVE;
							end
						end
					end
					PH_FMT_BODY: begin
						unique case (cnt_q[3:0])
							4'd0:  tag_d[7:0]    = data_byte;
							4'd1:  tag_d[15:8]   = data_byte;
							4'd2:  chans_d[7:0]  = data_byte;
							4'd3:  chans_d[15:8] = data_byte;
							4'd4:  rate_d[7:0]   = data_byte;
							4'd5:  rate_d[15:8]  = data_byte;
							4'd6:  rate_d[23:16] = data_byte;
							4'd7:  rate_d[31:24] = data_byte;
							4'd8:  brate_d[7:0]   = data_byte;
							4'd9:  brate_d[15:8]  = data_byte;
							4'd10: brate_d[23:16] = data_byte;
							4'd11: brate_d[31:24] = data_byte;
							4'd12: align_d[7:0]  = data_byte;
							4'd13: align_d[15:8] = data_byte;
							4'd14: bits_d[7:0]   = data_byte;
							default: bits_d[15:8] = data_byte;
						endcase
						if (bump == 6'(wrp_pkg::FMT_BODY_BYTES)) begin
							cnt_d   = '0;
							shift_d = '0;
							if (tag_q == wrp_pkg::TAG_EXTENSIBLE) begin
								phase_d = PH_FMT_EXT;
							end else begin
								phase_d = PH_ID;
								push    = 1'b1;
								push_entry.event_res        = wrp_pkg::EV_FORMAT;
								push_entry.format_tag       = tag_q;
								push_entry.channel_count    = chans_q;
								push_entry.rate_hz          = rate_q;
								push_entry.bytes_per_second = brate_q;
								push_entry.frame_bytes      = align_q;
								push_entry.sample_bits      = {data_byte, bits_q[7:0]};
							end
						end
					end
					PH_FMT_EXT: begin
						if (bump == 6'(wrp_pkg::FMT_EXT_BYTES)) begin
							cnt_d   = '0;
							shift_d = '0;
							phase_d = PH_ID;
							push    = 1'b1;
							push_entry.event_res        = wrp_pkg::EV_FORMAT;
							push_entry.format_tag       = tag_q;
							push_entry.channel_count    = chans_q;
							push_entry.rate_hz          = rate_q;
							push_entry.bytes_per_second = brate_q;
							push_entry.frame_bytes      = align_q;
							push_entry.sample_bits      = bits_q;
						end
					end
					PH_DATA_SIZE: begin
						shift_d = sh_le;
						if (bump == 6'd4) begin
							cnt_d   = '0;
							shift_d = '0;
							chan_d  = '0;
							fb_d    = fb_fmt;
							nb_d    = nb_fmt;
							left_d  = sh_le;
							if (bad_fmt) begin
								push = 1'b1;
								push_entry.event_res = wrp_pkg::EV_BAD_DATA;
								phase_d = (sh_le != 32'd0) ? PH_SKIP : PH_ID;
							end else if (sh_le >= {14'd0, fb_fmt}) begin
								phase_d = PH_SAMPLE;
							end else begin
								phase_d = (sh_le != 32'd0) ? PH_SKIP : PH_ID;
							end
						end
					end
					PH_SAMPLE: begin
						shift_d = sh_le;
						left_d  = left_dec;
						if (bump[1:0] == nb_q) begin
							cnt_d   = '0;
							shift_d = '0;
							push    = 1'b1;
							push_entry.event_res     = wrp_pkg::EV_SAMPLE;
							push_entry.raw           = sh_le[23:0];
							push_entry.nb            = nb_q;
							push_entry.channel_index = chan_q;
							chan_d = chan_q + 16'd1;
							// frame complete: go on only while a whole frame remains
							if (chan_d >= chans_q) begin
								chan_d = '0;
								if (left_dec < {14'd0, fb_q})
									phase_d = (left_dec != 32'd0) ? PH_SKIP : PH_ID;
							end
						end
					end
					PH_UNK_SIZE: begin
						shift_d = sh_le;
						if (bump == 6'd4) begin
							cnt_d   = '0;
							shift_d = '0;
							left_d  = sh_le;
							phase_d = (sh_le != 32'd0) ? PH_SKIP : PH_ID;
							push    = 1'b1;
							push_entry.event_res  = wrp_pkg::EV_SKIPPED;
							push_entry.skipped_id = left_q;
						end
					end
					PH_SKIP: begin
						cnt_d  = cnt_q;
						left_d = left_dec;
						if (left_dec == 32'd0) phase_d = PH_ID;
					end
					default: begin
						cnt_d = cnt_q;
					end
				endcase
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			cnt_q   <= '0;
			shift_q <= '0;
			left_q  <= '0;
			chan_q  <= '0;
			tag_q   <= '0;
			chans_q <= '0;
			rate_q  <= '0;
			brate_q <= '0;
			align_q <= '0;
			bits_q  <= '0;
			fb_q    <= '0;
			nb_q    <= wrp_pkg::NB_8;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			left_q  <= left_d;
			chan_q  <= chan_d;
			tag_q   <= tag_d;
			chans_q <= chans_d;
			rate_q  <= rate_d;
			brate_q <= brate_d;
			align_q <= align_d;
			bits_q  <= bits_d;
			fb_q    <= fb_d;
			nb_q    <= nb_d;
		end
	end

endmodule

/* hdl/wrp_queue.sv */
`timescale 1ns / 1ps
// small fifo of classified results between parser and converter
// depends on wrp_pkg
module wrp_queue #(
	parameter int Depth = wrp_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wrp_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output wrp_pkg::entry_t head_entry
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	wrp_pkg::entry_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

/* hdl/wrp_back.sv */
`timescale 1ns / 1ps
// sample converter to signed q23 and the output register
// depends on wrp_pkg
module wrp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  wrp_pkg::entry_t head_entry,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      event_res,
	output logic signed [24:0] sample_value,
	output logic [15:0]     channel_index,
	output logic [15:0]     format_tag,
	output logic [15:0]     channel_count,
	output logic [31:0]     rate_hz,
	output logic [31:0]     bytes_per_second,
	output logic [15:0]     frame_bytes,
	output logic [15:0]     sample_bits,
	output logic [31:0]     skipped_id
);

	logic        valid_q;
	logic [24:0] conv;
	logic [25:0] u8;
	logic [16:0] mag16;
	logic [23:0] x16;
	logic [8:0]  q16;
	logic [15:0] rem16;
	logic [24:0] r16;
	logic [24:0] mag24;
	logic [24:0] r24;
	logic        neg;
	logic [24:0] mag;

	assign pop       = head_valid && (!valid_q || !out_stall);
	assign out_valid = valid_q;

	// q23 conversion, rounded to nearest
	always_comb begin
		// 8 bit: b*2^24/255 = b*65793 + b/255, offset by one half scale
		u8 = {18'd0, head_entry.raw[7:0]} * 26'd65793
			+ {25'd0, head_entry.raw[7]} - 26'h0800000;
		// 16 bit: |s|*2^23/32767 = 256|s| + 256|s|/32767
		mag16 = head_entry.raw[15] ? (17'h10000 - {1'b0, head_entry.raw[15:0]})
			: {1'b0, head_entry.raw[15:0]};
		x16   = {mag16[15:0], 8'd0} + {mag16[16], 23'd0} + 24'd16383;
		q16   = x16[23:15];
		rem16 = {1'b0, x16[14:0]} + {7'd0, q16};
		r16   = {mag16, 8'd0} + {16'd0, q16} + {24'd0, (rem16 >= 16'd32767)};
		// 24 bit: |s|*2^23/8388607 = |s| + |s|/8388607
		mag24 = head_entry.raw[23] ? (25'h1000000 - {1'b0, head_entry.raw})
			: {1'b0, head_entry.raw};
		r24   = mag24 + {24'd0, (mag24 >= 25'h0400000)};
		unique case (head_entry.nb)
			wrp_pkg::NB_16: begin
				neg = head_entry.raw[15];
				mag = r16;
			end
			wrp_pkg::NB_24: begin
				neg = head_entry.raw[23];
				mag = r24;
			end
			default: begin
				neg = 1'b0;
				mag = u8[24:0];
			end
		endcase
		if (head_entry.event_res != wrp_pkg::EV_SAMPLE) conv = '0;
		else conv = neg ? (25'd0 - mag) : mag;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			event_res        <= head_entry.event_res;
			sample_value     <= conv;
			channel_index    <= head_entry.channel_index;
			format_tag       <= head_entry.format_tag;
			channel_count    <= head_entry.channel_count;
			rate_hz          <= head_entry.rate_hz;
			bytes_per_second <= head_entry.bytes_per_second;
			frame_bytes      <= head_entry.frame_bytes;
			sample_bits      <= head_entry.sample_bits;
			skipped_id       <= head_entry.skipped_id;
		end
	end

endmodule

/* hdl/wav_riff_pcm_stream_parser_top.sv */
`timescale 1ns / 1ps
// top level of the wav riff pcm stream parser
// depends on wrp_pkg, wrp_front, wrp_queue, wrp_back
//
// Takes a WAV file one byte per beat and reports format, sample, error and
// skipped-chunk events. One byte is accepted every cycle while in_stall is low;
// in_stall rises only when the result queue between the byte parser and the
// sample converter is full, which happens only while out_stall holds results
// back. Each result is held in the result queue and then in the output
// register. Samples of 8, 16 and 24 bits come out as signed Q23 with their
// channel index; only whole frames are emitted. cmd high restarts the parser
// for a new file while results already queued are still delivered.
module wav_riff_pcm_stream_parser_top #(
	parameter int QueueDepth = wrp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         event_res,
	output logic signed [24:0] sample_value,
	output logic [15:0]        channel_index,
	output logic [15:0]        format_tag,
	output logic [15:0]        channel_count,
	output logic [31:0]        rate_hz,
	output logic [31:0]        bytes_per_second,
	output logic [15:0]        frame_bytes,
	output logic [15:0]        sample_bits,
	output logic [31:0]        skipped_id
);

	logic            accept;
	logic            push;
	logic            pop;
	logic            full;
	logic            head_valid;
	wrp_pkg::entry_t push_entry;
	wrp_pkg::entry_t head_entry;

	// input beat handshake
	assign in_stall = full;
	assign accept   = in_valid && !full;

	wrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	wrp_queue #(.Depth(QueueDepth)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	wrp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head_entry       (head_entry),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_res        (event_res),
		.sample_value     (sample_value),
		.channel_index    (channel_index),
		.format_tag       (format_tag),
		.channel_count    (channel_count),
		.rate_hz          (rate_hz),
		.bytes_per_second (bytes_per_second),
		.frame_bytes      (frame_bytes),
		.sample_bits      (sample_bits),
		.skipped_id       (skipped_id)
	);

endmodule
